>>> src/ssvf_pkg.sv
// ----------------------------------------------------------------------------
// ssvf_pkg
// Types and constants shared by the seven-segment value formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package ssvf_pkg;

  localparam int unsigned DigitCount = 8;

  // binary to bcd lanes: lane a holds the main value, lane b the pot voltage
  localparam int unsigned BinWidthA  = 16;
  localparam int unsigned BinWidthB  = 10;
  localparam int unsigned BcdDigitsA = 5;
  localparam int unsigned BcdDigitsB = 4;
  localparam int unsigned StepsA     = BinWidthA / 2;
  localparam int unsigned StepsB     = BinWidthB / 2;

  typedef logic [3:0] digit_t;

  localparam digit_t CodeBlank = 4'd10;
  localparam digit_t CodeDash  = 4'd11;

  localparam logic [2:0] ModeFreq   = 3'd0;
  localparam logic [2:0] ModeDist   = 3'd1;
  localparam logic [2:0] ModeTime   = 3'd2;
  localparam logic [2:0] ModeVolts  = 3'd3;
  localparam logic [2:0] ModeTemp   = 3'd4;
  localparam logic [2:0] ModeSaved  = 3'd5;

  localparam logic [DigitCount-1:0] MaskVolts = 8'b0010_0010;
  localparam logic [DigitCount-1:0] MaskTemp  = 8'b0010_0000;

  typedef struct packed {
    logic [2:0]                  mode;
    logic [BinWidthA-1:0]        bin_a;
    logic [BinWidthB-1:0]        bin_b;
    digit_t [BcdDigitsA-1:0]     bcd_a;
    digit_t [BcdDigitsB-1:0]     bcd_b;
    digit_t [5:0]                hms_dig;
  } pipe_t;

  typedef struct packed {
    digit_t [DigitCount-1:0]     digit;
    logic [DigitCount-1:0]       point_mask;
  } frame_t;

endpackage

`default_nettype wire

>>> src/ssvf_if.sv
// ----------------------------------------------------------------------------
// ssvf_if
// Valid/ready channels for readings in and display frames out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssvf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [15:0] frequency;
  logic [9:0]  distance;
  logic [4:0]  hours;
  logic [5:0]  minutes;
  logic [5:0]  seconds;
  logic [9:0]  light_volts;
  logic [9:0]  pot_volts;
  logic [13:0] temp_hundredths;
  logic [15:0] saved_value;

  modport source (
    output valid, mode, frequency, distance, hours, minutes, seconds,
           light_volts, pot_volts, temp_hundredths, saved_value,
    input  ready
  );
  modport sink (
    input  valid, mode, frequency, distance, hours, minutes, seconds,
           light_volts, pot_volts, temp_hundredths, saved_value,
    output ready
  );
endinterface

interface ssvf_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit_0;
  logic [3:0] digit_1;
  logic [3:0] digit_2;
  logic [3:0] digit_3;
  logic [3:0] digit_4;
  logic [3:0] digit_5;
  logic [3:0] digit_6;
  logic [3:0] digit_7;
  logic [7:0] point_mask;

  modport source (
    output valid, digit_0, digit_1, digit_2, digit_3, digit_4, digit_5,
           digit_6, digit_7, point_mask,
    input  ready
  );
  modport sink (
    input  valid, digit_0, digit_1, digit_2, digit_3, digit_4, digit_5,
           digit_6, digit_7, point_mask,
    output ready
  );
endinterface

`default_nettype wire

>>> src/ssvf_select.sv
// ----------------------------------------------------------------------------
// ssvf_select
// First stage: picks the value to convert and splits the clock fields.
// ----------------------------------------------------------------------------
`default_nettype none

module ssvf_select (
  input  logic              clk_i,
  input  logic              rst_ni,
  ssvf_in_if.sink           in_i,
  output logic              valid_o,
  output ssvf_pkg::pipe_t   data_o,
  input  logic              ready_i
);

  logic            valid_q;
  ssvf_pkg::pipe_t data_d;
  ssvf_pkg::pipe_t data_q;
  logic            load;

  function automatic ssvf_pkg::digit_t tens_of(input logic [5:0] v);
    ssvf_pkg::digit_t t;
    t = 4'd0;
    for (int k = 1; k <= 6; k++) begin
      if (v >= 6'(10 * k)) t = 4'(k);
    end
    return t;
  endfunction

  function automatic ssvf_pkg::digit_t units_of(input logic [5:0] v);
    logic [5:0] u;
    u = v - ({2'b00, tens_of(v)} * 6'd10);
    return u[3:0];
  endfunction

  assign in_i.ready = !valid_q || ready_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    data_d       = '0;
    data_d.mode  = in_i.mode;
    data_d.bin_b = in_i.pot_volts;
    case (in_i.mode) inside
      ssvf_pkg::ModeFreq:  data_d.bin_a = in_i.frequency;
      ssvf_pkg::ModeSaved: data_d.bin_a = in_i.saved_value;
      ssvf_pkg::ModeDist:  data_d.bin_a = {6'd0, in_i.distance};
      ssvf_pkg::ModeVolts: data_d.bin_a = {6'd0, in_i.light_volts};
      ssvf_pkg::ModeTemp:  data_d.bin_a = {2'd0, in_i.temp_hundredths};
      default:             data_d.bin_a = '0;
    endcase
    data_d.hms_dig[0] = tens_of({1'b0, in_i.hours});
    data_d.hms_dig[1] = units_of({1'b0, in_i.hours});
    data_d.hms_dig[2] = tens_of(in_i.minutes);
    data_d.hms_dig[3] = units_of(in_i.minutes);
    data_d.hms_dig[4] = tens_of(in_i.seconds);
    data_d.hms_dig[5] = units_of(in_i.seconds);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

>>> src/ssvf_dabble.sv
// ----------------------------------------------------------------------------
// ssvf_dabble
// Pipeline stage doing half of the shift-and-add-3 steps on both lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module ssvf_dabble (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  ssvf_pkg::pipe_t   data_i,
  output logic              ready_o,
  output logic              valid_o,
  output ssvf_pkg::pipe_t   data_o,
  input  logic              ready_i
);

  logic            valid_q;
  ssvf_pkg::pipe_t data_d;
  ssvf_pkg::pipe_t data_q;
  logic            load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    data_d = data_i;
    for (int s = 0; s < ssvf_pkg::StepsA; s++) begin
      for (int k = 0; k < ssvf_pkg::BcdDigitsA; k++) begin
        if (data_d.bcd_a[k] >= 4'd5) data_d.bcd_a[k] = data_d.bcd_a[k] + 4'd3;
      end
      {data_d.bcd_a, data_d.bin_a} = {data_d.bcd_a, data_d.bin_a} << 1;
    end
    for (int s = 0; s < ssvf_pkg::StepsB; s++) begin
      for (int k = 0; k < ssvf_pkg::BcdDigitsB; k++) begin
        if (data_d.bcd_b[k] >= 4'd5) data_d.bcd_b[k] = data_d.bcd_b[k] + 4'd3;
      end
      {data_d.bcd_b, data_d.bin_b} = {data_d.bcd_b, data_d.bin_b} << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

>>> src/ssvf_format.sv
// ----------------------------------------------------------------------------
// ssvf_format
// Last stage: places digits, blanks and dashes per mode into the frame
// ----------------------------------------------------------------------------
`default_nettype none

module ssvf_format (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  ssvf_pkg::pipe_t   data_i,
  output logic              ready_o,
  ssvf_out_if.source        out_o
);

  logic                                   valid_q;
  ssvf_pkg::frame_t                       frame_d;
  ssvf_pkg::frame_t                       frame_q;
  logic [ssvf_pkg::BcdDigitsA-1:0]        nz;
  logic                                   load;

  assign ready_o = !valid_q || out_o.ready;
  assign load    = valid_i && ready_o;

  // nz[k]: some digit at position k or above is nonzero
  always_comb begin
    nz[ssvf_pkg::BcdDigitsA-1] = data_i.bcd_a[ssvf_pkg::BcdDigitsA-1] != 4'd0;
    for (int k = ssvf_pkg::BcdDigitsA - 2; k >= 0; k--) begin
      nz[k] = nz[k+1] || (data_i.bcd_a[k] != 4'd0);
    end
  end

  always_comb begin
    for (int i = 0; i < ssvf_pkg::DigitCount; i++) begin
      frame_d.digit[i] = ssvf_pkg::CodeBlank;
    end
    frame_d.point_mask = '0;
    unique case (data_i.mode) inside
      ssvf_pkg::ModeFreq, ssvf_pkg::ModeSaved: begin
        frame_d.digit[3] = nz[4] ? data_i.bcd_a[4] : ssvf_pkg::CodeBlank;
        frame_d.digit[4] = nz[3] ? data_i.bcd_a[3] : ssvf_pkg::CodeBlank;
        frame_d.digit[5] = nz[2] ? data_i.bcd_a[2] : ssvf_pkg::CodeBlank;
        frame_d.digit[6] = nz[1] ? data_i.bcd_a[1] : ssvf_pkg::CodeBlank;
        frame_d.digit[7] = data_i.bcd_a[0];
      end
      ssvf_pkg::ModeDist: begin
        frame_d.digit[5] = nz[2] ? data_i.bcd_a[2] : ssvf_pkg::CodeBlank;
        frame_d.digit[6] = nz[1] ? data_i.bcd_a[1] : ssvf_pkg::CodeBlank;
        frame_d.digit[7] = data_i.bcd_a[0];
      end
      ssvf_pkg::ModeTime: begin
        frame_d.digit[0] = data_i.hms_dig[0];
        frame_d.digit[1] = data_i.hms_dig[1];
        frame_d.digit[2] = ssvf_pkg::CodeDash;
        frame_d.digit[3] = data_i.hms_dig[2];
        frame_d.digit[4] = data_i.hms_dig[3];
        frame_d.digit[5] = ssvf_pkg::CodeDash;
        frame_d.digit[6] = data_i.hms_dig[4];
        frame_d.digit[7] = data_i.hms_dig[5];
      end
      ssvf_pkg::ModeVolts: begin
        frame_d.digit[1]   = data_i.bcd_a[2];
        frame_d.digit[2]   = data_i.bcd_a[1];
        frame_d.digit[3]   = data_i.bcd_a[0];
        frame_d.digit[5]   = data_i.bcd_b[2];
        frame_d.digit[6]   = data_i.bcd_b[1];
        frame_d.digit[7]   = data_i.bcd_b[0];
        frame_d.point_mask = ssvf_pkg::MaskVolts;
      end
      ssvf_pkg::ModeTemp: begin
        frame_d.digit[4]   = nz[3] ? data_i.bcd_a[3] : ssvf_pkg::CodeBlank;
        frame_d.digit[5]   = data_i.bcd_a[2];
        frame_d.digit[6]   = data_i.bcd_a[1];
        frame_d.digit[7]   = data_i.bcd_a[0];
        frame_d.point_mask = ssvf_pkg::MaskTemp;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= frame_d;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.digit_0    = frame_q.digit[0];
  assign out_o.digit_1    = frame_q.digit[1];
  assign out_o.digit_2    = frame_q.digit[2];
  assign out_o.digit_3    = frame_q.digit[3];
  assign out_o.digit_4    = frame_q.digit[4];
  assign out_o.digit_5    = frame_q.digit[5];
  assign out_o.digit_6    = frame_q.digit[6];
  assign out_o.digit_7    = frame_q.digit[7];
  assign out_o.point_mask = frame_q.point_mask;

endmodule

`default_nettype wire

>>> src/seven_segment_value_formatter.sv
// ----------------------------------------------------------------------------
// seven_segment_value_formatter
// Turns a display mode and readings into eight digit codes and a point mask.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    mode and all readings
//   out_o    out  valid/ready    digit_0..digit_7, point_mask
//
// four register stages: select, two bcd conversion stages, format/output.
// one transaction per cycle while out_o is not stalled.
// each stage holds its own valid bit and takes new data when empty or when
// the stage after it moves, so bubbles close up behind a stalled output.
// reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_value_formatter (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssvf_in_if.sink     in_i,
  ssvf_out_if.source  out_o
);

  logic            s1_valid;
  logic            s1_ready;
  ssvf_pkg::pipe_t s1_data;
  logic            s2_valid;
  logic            s2_ready;
  ssvf_pkg::pipe_t s2_data;
  logic            s3_valid;
  logic            s3_ready;
  ssvf_pkg::pipe_t s3_data;

  ssvf_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (s1_valid),
    .data_o  (s1_data),
    .ready_i (s1_ready)
  );

  ssvf_dabble u_dabble_hi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .data_i  (s1_data),
    .ready_o (s1_ready),
    .valid_o (s2_valid),
    .data_o  (s2_data),
    .ready_i (s2_ready)
  );

  ssvf_dabble u_dabble_lo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .data_i  (s2_data),
    .ready_o (s2_ready),
    .valid_o (s3_valid),
    .data_o  (s3_data),
    .ready_i (s3_ready)
  );

  ssvf_format u_format (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_valid),
    .data_i  (s3_data),
    .ready_o (s3_ready),
    .out_o   (out_o)
  );

`ifndef SYNTHESIS
  // input only backs up when every stage is full and the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_valid && s2_valid && s3_valid && out_o.valid && !out_o.ready))
    else $error("input stalled with room in the pipeline");

  // only the points after digits 1 and 5 are ever lit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.point_mask & ~(ssvf_pkg::MaskVolts)) == 8'd0))
    else $error("unexpected decimal point");

  // every digit code is a numeral, blank or dash
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.digit_0 <= ssvf_pkg::CodeDash && out_o.digit_1 <= ssvf_pkg::CodeDash
      && out_o.digit_2 <= ssvf_pkg::CodeDash && out_o.digit_3 <= ssvf_pkg::CodeDash
      && out_o.digit_4 <= ssvf_pkg::CodeDash && out_o.digit_5 <= ssvf_pkg::CodeDash
      && out_o.digit_6 <= ssvf_pkg::CodeDash && out_o.digit_7 <= ssvf_pkg::CodeDash))
    else $error("digit code out of range");

  // the last conversion stage, if valid and unable to move, still holds its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid && !s3_ready) |=> s3_valid)
    else $error("transaction lost in conversion stage");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the seven-segment value formatter: readings go in
// on a valid/ready channel, and every display frame that comes out is checked
// against frames predicted from the accepted readings, oldest first. Both
// sides idle at random, and some stretches run with no idling at all.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ssvf_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned RandomCount = 530;
  localparam int unsigned PhaseCount  = 4;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] frequency;
    logic [9:0]  distance;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [9:0]  light_volts;
    logic [9:0]  pot_volts;
    logic [13:0] temp_hundredths;
    logic [15:0] saved_value;
  } reading_t;

  class frame_scoreboard;
    frame_t      frame_q[$];
    int unsigned errors = 0;

    function digit_t digit_at(int unsigned v, int unsigned pow10);
      return digit_t'((v / pow10) % 10);
    endfunction

    function digit_t lead_digit_at(int unsigned v, int unsigned pow10);
      return (v >= pow10) ? digit_at(v, pow10) : CodeBlank;
    endfunction

    function void put_five(ref frame_t f, input int unsigned v);
      f.digit[3] = lead_digit_at(v, 10000);
      f.digit[4] = lead_digit_at(v, 1000);
      f.digit[5] = lead_digit_at(v, 100);
      f.digit[6] = lead_digit_at(v, 10);
      f.digit[7] = digit_at(v, 1);
    endfunction

    function frame_t format_frame(reading_t r);
      frame_t f;
      for (int i = 0; i < DigitCount; i++) f.digit[i] = CodeBlank;
      f.point_mask = '0;
      case (r.mode)
        ModeFreq: begin
          put_five(f, r.frequency);
        end
        ModeSaved: begin
          put_five(f, r.saved_value);
        end
        ModeDist: begin
          f.digit[5] = lead_digit_at(r.distance, 100);
          f.digit[6] = lead_digit_at(r.distance, 10);
          f.digit[7] = digit_at(r.distance, 1);
        end
        ModeTime: begin
          f.digit[0] = digit_t'(r.hours / 10);
          f.digit[1] = digit_t'(r.hours % 10);
          f.digit[2] = CodeDash;
          f.digit[3] = digit_t'(r.minutes / 10);
          f.digit[4] = digit_t'(r.minutes % 10);
          f.digit[5] = CodeDash;
          f.digit[6] = digit_t'(r.seconds / 10);
          f.digit[7] = digit_t'(r.seconds % 10);
        end
        ModeVolts: begin
          f.digit[1] = digit_at(r.light_volts, 100);
          f.digit[2] = digit_at(r.light_volts, 10);
          f.digit[3] = digit_at(r.light_volts, 1);
          f.digit[5] = digit_at(r.pot_volts, 100);
          f.digit[6] = digit_at(r.pot_volts, 10);
          f.digit[7] = digit_at(r.pot_volts, 1);
          f.point_mask = MaskVolts;
        end
        ModeTemp: begin
          f.digit[4] = lead_digit_at(r.temp_hundredths, 1000);
          f.digit[5] = digit_at(r.temp_hundredths, 100);
          f.digit[6] = digit_at(r.temp_hundredths, 10);
          f.digit[7] = digit_at(r.temp_hundredths, 1);
          f.point_mask = MaskTemp;
        end
        default: begin
        end
      endcase
      return f;
    endfunction

    function void note_reading(reading_t r);
      frame_q.push_back(format_frame(r));
    endfunction

    function void check_frame(frame_t got);
      frame_t exp_f;
      if (frame_q.size() == 0) begin
        $display("%0t: unexpected frame, expected none, got %h", $time, got);
        errors++;
        return;
      end
      exp_f = frame_q.pop_front();
      for (int i = 0; i < DigitCount; i++) begin
        if (got.digit[i] !== exp_f.digit[i]) begin
          $display("%0t: digit_%0d expected %0d got %0d", $time, i, exp_f.digit[i],
                   got.digit[i]);
          errors++;
        end
      end
      if (got.point_mask !== exp_f.point_mask) begin
        $display("%0t: point_mask expected %b got %b", $time, exp_f.point_mask,
                 got.point_mask);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return frame_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  int unsigned cycles = 0;
  bit          tx_eager;
  bit          rx_eager;

  frame_scoreboard frames = new();

  ssvf_in_if  in_if ();
  ssvf_out_if out_if ();

  seven_segment_value_formatter i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function reading_t filled(logic [2:0] m, logic [31:0] v);
    reading_t r;
    r.mode            = m;
    r.frequency       = v[15:0];
    r.distance        = v[9:0];
    r.hours           = v[4:0];
    r.minutes         = v[5:0];
    r.seconds         = v[5:0];
    r.light_volts     = v[9:0];
    r.pot_volts       = v[9:0];
    r.temp_hundredths = v[13:0];
    r.saved_value     = v[15:0];
    return r;
  endfunction

  function reading_t random_reading();
    reading_t r;
    bit       wide;
    wide = ($urandom_range(0, 4) == 0);
    r.mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                         : 3'($urandom_range(0, 5));
    r.frequency       = 16'($urandom_range(0, 65535));
    r.saved_value     = 16'($urandom_range(0, 65535));
    r.distance        = 10'(wide ? $urandom_range(0, 1023) : $urandom_range(0, 999));
    r.hours           = 5'(wide ? $urandom_range(0, 31) : $urandom_range(0, 23));
    r.minutes         = 6'(wide ? $urandom_range(0, 63) : $urandom_range(0, 59));
    r.seconds         = 6'(wide ? $urandom_range(0, 63) : $urandom_range(0, 59));
    r.light_volts     = 10'(wide ? $urandom_range(0, 1023) : $urandom_range(0, 999));
    r.pot_volts       = 10'(wide ? $urandom_range(0, 1023) : $urandom_range(0, 999));
    r.temp_hundredths = 14'(wide ? $urandom_range(0, 16383) : $urandom_range(0, 9999));
    // small values exercise leading blanks
    if ($urandom_range(0, 3) == 0) begin
      r.frequency       = 16'($urandom_range(0, 120));
      r.saved_value     = 16'($urandom_range(0, 1200));
      r.distance        = 10'($urandom_range(0, 120));
      r.temp_hundredths = 14'($urandom_range(0, 1200));
    end
    return r;
  endfunction

  task automatic send_reading(reading_t r);
    int unsigned gap;
    gap = tx_eager ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.mode            <= r.mode;
    in_if.frequency       <= r.frequency;
    in_if.distance        <= r.distance;
    in_if.hours           <= r.hours;
    in_if.minutes         <= r.minutes;
    in_if.seconds         <= r.seconds;
    in_if.light_volts     <= r.light_volts;
    in_if.pot_volts       <= r.pot_volts;
    in_if.temp_hundredths <= r.temp_hundredths;
    in_if.saved_value     <= r.saved_value;
    forever begin
      @(negedge clk);
      if (in_if.ready) break;
    end
    @(posedge clk);
    frames.note_reading(r);
  endtask

  task automatic wait_drained();
    while (frames.pending() != 0) @(posedge clk);
  endtask

  task automatic send_directed();
    reading_t r;
    send_reading(filled(ModeFreq, 0));
    send_reading(filled(ModeFreq, 9));
    send_reading(filled(ModeFreq, 10000));
    send_reading(filled(ModeFreq, 65535));
    send_reading(filled(ModeDist, 0));
    send_reading(filled(ModeDist, 99));
    send_reading(filled(ModeDist, 100));
    send_reading(filled(ModeDist, 1023));
    send_reading(filled(ModeTime, 0));
    r = filled(ModeTime, 59);
    r.hours = 5'd23;
    send_reading(r);
    send_reading(filled(ModeTime, 32'hffff_ffff));
    send_reading(filled(ModeVolts, 0));
    send_reading(filled(ModeVolts, 999));
    send_reading(filled(ModeVolts, 1023));
    send_reading(filled(ModeTemp, 0));
    send_reading(filled(ModeTemp, 999));
    send_reading(filled(ModeTemp, 1000));
    send_reading(filled(ModeTemp, 9999));
    send_reading(filled(ModeTemp, 16383));
    send_reading(filled(ModeSaved, 0));
    send_reading(filled(ModeSaved, 65535));
    send_reading(filled(3'd6, 32'hffff_ffff));
    send_reading(filled(3'd7, 32'h0001_2345));
  endtask

  // frame receiver
  initial begin
    frame_t got;
    int unsigned stall;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = rx_eager ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      forever begin
        @(negedge clk);
        if (out_if.valid) break;
      end
      got.digit[0]   = out_if.digit_0;
      got.digit[1]   = out_if.digit_1;
      got.digit[2]   = out_if.digit_2;
      got.digit[3]   = out_if.digit_3;
      got.digit[4]   = out_if.digit_4;
      got.digit[5]   = out_if.digit_5;
      got.digit[6]   = out_if.digit_6;
      got.digit[7]   = out_if.digit_7;
      got.point_mask = out_if.point_mask;
      @(posedge clk);
      frames.check_frame(got);
    end
  end

  // reset and reading transactions
  initial begin
    rst_n                 = 1'b0;
    tx_eager              = 1'b0;
    rx_eager              = 1'b0;
    in_if.valid           = 1'b0;
    in_if.mode            = '0;
    in_if.frequency       = '0;
    in_if.distance        = '0;
    in_if.hours           = '0;
    in_if.minutes         = '0;
    in_if.seconds         = '0;
    in_if.light_volts     = '0;
    in_if.pot_volts       = '0;
    in_if.temp_hundredths = '0;
    in_if.saved_value     = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_directed();

    for (int p = 0; p < PhaseCount; p++) begin
      // phases: both idle, sender eager, receiver eager, both eager
      tx_eager = (p == 1) || (p == 3);
      rx_eager = (p == 2) || (p == 3);
      for (int n = 0; n < RandomCount / PhaseCount; n++) begin
        send_reading(random_reading());
        if (n == 40) begin
          in_if.valid <= 1'b0;
          wait_drained();
        end
      end
    end

    in_if.valid <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (frames.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
